// ===== hdl/gpst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpst_pkg: shared codes for the generational process slot table
// Slot phases, request modes, result status codes and fixed id constants.
// ----------------------------------------------------------------------------
package gpst_pkg;

  typedef enum logic [1:0] {
    PH_EMPTY   = 2'd0,
    PH_READY   = 2'd1,
    PH_RUNNING = 2'd2,
    PH_ZOMBIE  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    MODE_SPAWN  = 3'd0,
    MODE_INIT   = 3'd1,
    MODE_START  = 3'd2,
    MODE_EXIT   = 3'd3,
    MODE_WAIT   = 3'd4,
    MODE_TERM   = 3'd5,
    MODE_STAT   = 3'd6,
    MODE_CENSUS = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_INVALID      = 4'd1,
    ST_TOO_LONG     = 4'd2,
    ST_FULL         = 4'd3,
    ST_THREAD_FAIL  = 4'd4,
    ST_NOT_FOUND    = 4'd5,
    ST_DENIED       = 4'd6,
    ST_WOULD_BLOCK  = 4'd7,
    ST_RUNNER_FAIL  = 4'd8,
    ST_ALREADY_INIT = 4'd9,
    ST_BAD_STATE    = 4'd10
  } status_t;

  // Path check codes
  localparam logic [1:0] PATH_OK   = 2'd0;
  localparam logic [1:0] PATH_LONG = 2'd2;

  // Low byte of an id carries the slot number plus one
  localparam int unsigned SLOT_BITS = 8;
  localparam logic [31:0] INIT_ID   = 32'd1;
  localparam logic [6:0]  ZC_MAX    = 7'd127;

endpackage

// ===== hdl/generational_process_slot_table_unit.sv =====
`timescale 1ns / 1ps
// A rejected request (bad spawn path, malformed id) is answered from the idle state;
// init, start, exit, wait, terminate and stat read the addressed slot, then execute.
// Spawn and zombie census walk the slot memory one slot per cycle through its
// single read port (spawn stops at the first free slot).
// A new request is taken in the cycle its result strobe is up; the receiver
// cannot stall. Synchronous reset empties every slot and clears init.
// ----------------------------------------------------------------------------
// generational_process_slot_table_unit: process slot table with tagged ids
// Sequencer around one slot record memory; ids are generation << 8 | slot+1.
// ----------------------------------------------------------------------------
module generational_process_slot_table_unit
  import gpst_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int GEN_BITS  = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [2:0]         mode,
  input  logic [31:0]        target_id,
  input  logic [31:0]        caller_id,
  input  logic signed [31:0] exit_code_in,
  input  logic [1:0]         path_check,
  input  logic               thread_ok,
  input  logic               runner_ok,
  output logic [3:0]         status,
  output logic [31:0]        result_id,
  output logic [31:0]        parent_id,
  output logic [1:0]         proc_state,
  output logic signed [31:0] exit_value,
  output logic [6:0]         zombie_count
);

  // Slot address width and a scan counter wide enough to hold NUM_SLOTS
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SLOTS - 1);

  typedef struct packed {
    logic [31:0]         id;
    logic [31:0]         parent;
    logic [GEN_BITS-1:0] gen;
    phase_t              phase;
    logic [31:0]         code;
  } rec_t;

  localparam int RW = $bits(rec_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EXEC
  } state_t;

  state_t state_q;

  // Latched request
  mode_t       mode_q;
  logic [31:0] target_q;
  logic [31:0] caller_q;
  logic [31:0] code_q;
  logic [1:0]  pc_q;
  logic        thr_q;
  logic        run_q;

  // Sequencer registers
  logic [AW-1:0] slot_q;   // addressed slot for lookup operations
  logic [CW-1:0] cnt_q;    // scan issue pointer
  logic [AW-1:0] chk_q;    // slot whose record is on the read port
  logic          pend_q;   // read port holds a scanned record
  logic [6:0]    zc_q;
  logic          init_done_q;

  // Memory interface
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] rd_data;
  rec_t          rec;
  logic          we;
  logic [AW-1:0] wa;
  rec_t          wd;

  // Lookup decode of the incoming id
  logic [7:0]    k_in;
  logic          idx_ok;
  logic          look_ok;

  // Spawn arithmetic
  logic [GEN_BITS-1:0] gen_inc;
  logic [GEN_BITS-1:0] gen_new;
  logic [7:0]          slot_num;
  logic [GEN_BITS+7:0] id_wide;
  logic [31:0]         id_new;

  // Result of this cycle
  logic        fin;
  status_t     r_st;
  logic [31:0] r_rid;
  logic [31:0] r_par;
  phase_t      r_ph;
  logic [31:0] r_ev;
  logic [6:0]  r_zc;
  logic [6:0]  zc_inc;
  logic        init_set;
  logic        accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Scan reads follow the issue pointer; everything else reads the addressed slot
  assign rd_addr = (state_q == S_SCAN) ? cnt_q[AW-1:0] : slot_q;

  gpst_slot_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (AW),
    .W     (RW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (we),
    .wr_addr (wa),
    .wr_data (wd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rec = rec_t'(rd_data);

  assign k_in   = target_id[7:0];
  assign idx_ok = (k_in != 8'd0) && ({1'b0, k_in} <= 9'(NUM_SLOTS));

  // A slot matches only when live and carrying exactly the requested id
  assign look_ok = (rec.phase != PH_EMPTY) && (rec.id == target_q);

  // Bump the generation, skipping zero on wrap
  assign gen_inc  = rec.gen + GEN_BITS'(1);
  assign gen_new  = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign slot_num = 8'(chk_q) + 8'd1;
  assign id_wide  = {gen_new, slot_num};
  assign id_new   = 32'(id_wide);

  assign zc_inc = ((rec.phase == PH_ZOMBIE) && (zc_q != ZC_MAX)) ? zc_q + 7'd1 : zc_q;

  // Decide this cycle's result and table write
  always_comb begin
    fin      = 1'b0;
    r_st     = ST_OK;
    r_rid    = '0;
    r_par    = '0;
    r_ph     = PH_EMPTY;
    r_ev     = '0;
    r_zc     = '0;
    we       = 1'b0;
    wa       = slot_q;
    wd       = rec;
    init_set = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // Reject what needs no table access right away
        if (accept) begin
          if (mode_t'(mode) == MODE_SPAWN) begin
            if (path_check != PATH_OK && path_check != PATH_LONG) begin
              fin  = 1'b1;
              r_st = ST_INVALID;
            end
          end else if (mode_t'(mode) != MODE_INIT && mode_t'(mode) != MODE_CENSUS) begin
            if (!idx_ok) begin
              fin  = 1'b1;
              r_st = ST_NOT_FOUND;
            end
          end
        end
      end
      S_SCAN: begin
        if (pend_q) begin
          if (mode_q == MODE_CENSUS) begin
            if (chk_q == LAST_SLOT) begin
              fin  = 1'b1;
              r_zc = zc_inc;
            end
          end else if (rec.phase == PH_EMPTY) begin
            // First free slot: a too-long path leaves it untouched
            fin = 1'b1;
            wa  = chk_q;
            if (pc_q == PATH_LONG) begin
              r_st = ST_TOO_LONG;
            end else if (!thr_q) begin
              we        = 1'b1;
              wd        = '0;
              wd.gen    = gen_new;
              r_st      = ST_THREAD_FAIL;
            end else begin
              we        = 1'b1;
              wd.id     = id_new;
              wd.parent = caller_q;
              wd.gen    = gen_new;
              wd.phase  = PH_READY;
              wd.code   = '0;
              r_rid     = id_new;
            end
          end else if (chk_q == LAST_SLOT) begin
            fin  = 1'b1;
            r_st = ST_FULL;
          end
        end
      end
      S_READ: begin
      end
      S_EXEC: begin
        fin = 1'b1;
        unique case (mode_q)
          MODE_INIT: begin
            if (init_done_q || rec.phase != PH_EMPTY) begin
              r_st = ST_ALREADY_INIT;
            end else if (pc_q == PATH_LONG) begin
              r_st = ST_TOO_LONG;
            end else if (pc_q != PATH_OK) begin
              r_st = ST_INVALID;
            end else if (!thr_q) begin
              r_st = ST_THREAD_FAIL;
            end else begin
              we        = 1'b1;
              wd.id     = INIT_ID;
              wd.parent = '0;
              wd.phase  = PH_READY;
              wd.code   = '0;
              init_set  = 1'b1;
              r_rid     = INIT_ID;
            end
          end
          MODE_START: begin
            if (!look_ok) begin
              r_st = ST_NOT_FOUND;
            end else if (rec.phase != PH_READY) begin
              r_st = ST_BAD_STATE;
            end else begin
              we       = 1'b1;
              wd.phase = PH_RUNNING;
            end
          end
          MODE_EXIT: begin
            if (!look_ok) begin
              r_st = ST_NOT_FOUND;
            end else if (rec.phase != PH_RUNNING) begin
              r_st = ST_BAD_STATE;
            end else begin
              we       = 1'b1;
              wd.phase = PH_ZOMBIE;
              wd.code  = code_q;
            end
          end
          MODE_WAIT: begin
            if (!look_ok) begin
              r_st = ST_NOT_FOUND;
            end else if (caller_q != '0 && rec.parent != caller_q) begin
              r_st = ST_DENIED;
            end else if (rec.phase != PH_ZOMBIE) begin
              r_st = ST_WOULD_BLOCK;
            end else begin
              // Reap: clear the slot, keep its generation
              r_ev   = rec.code;
              we     = 1'b1;
              wd     = '0;
              wd.gen = rec.gen;
            end
          end
          MODE_TERM: begin
            if (!look_ok) begin
              r_st = ST_NOT_FOUND;
            end else if (rec.phase != PH_ZOMBIE && !run_q) begin
              r_st = ST_RUNNER_FAIL;
            end
          end
          MODE_STAT: begin
            if (!look_ok) begin
              r_st = ST_NOT_FOUND;
            end else begin
              r_rid = rec.id;
              r_par = rec.parent;
              r_ph  = rec.phase;
              r_ev  = rec.code;
            end
          end
          MODE_SPAWN, MODE_CENSUS: begin
          end
        endcase
      end
    endcase
  end

  // Sequencer and registered result ports
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q     <= S_IDLE;
      done        <= 1'b0;
      init_done_q <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      done <= fin;
      if (fin) begin
        status       <= r_st;
        result_id    <= r_rid;
        parent_id    <= r_par;
        proc_state   <= r_ph;
        exit_value   <= $signed(r_ev);
        zombie_count <= r_zc;
      end
      if (init_set) begin
        init_done_q <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            // Hold the request for the whole operation
            mode_q   <= mode_t'(mode);
            target_q <= target_id;
            caller_q <= caller_id;
            code_q   <= $unsigned(exit_code_in);
            pc_q     <= path_check;
            thr_q    <= thread_ok;
            run_q    <= runner_ok;
            cnt_q    <= '0;
            pend_q   <= 1'b0;
            zc_q     <= '0;
            if (!fin) begin
              if (mode_t'(mode) == MODE_SPAWN || mode_t'(mode) == MODE_CENSUS) begin
                state_q <= S_SCAN;
              end else if (mode_t'(mode) == MODE_INIT) begin
                slot_q  <= '0;
                state_q <= S_READ;
              end else begin
                slot_q  <= AW'(k_in - 8'd1);
                state_q <= S_READ;
              end
            end
          end
        end
        S_SCAN: begin
          // Advance the issue pointer until every slot has been read
          if (cnt_q != CW'(NUM_SLOTS)) begin
            cnt_q  <= cnt_q + CW'(1);
            chk_q  <= cnt_q[AW-1:0];
            pend_q <= 1'b1;
          end
          if (pend_q) begin
            zc_q <= zc_inc;
          end
          if (fin) begin
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Every result follows an accepted request or a cycle of work
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state_q != S_IDLE) || $past(start && !busy))
    else $error("result strobe without a pending request");

  // The table changes only together with the result of the request
  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    we |-> fin)
    else $error("slot write without a result");

  // Init happens once per reset
  a_init_sticky: assert property (@(posedge clk) disable iff (rst)
    init_done_q |=> init_done_q)
    else $error("init flag dropped");

  // A census count never exceeds the number of slots examined so far
  a_census_bound: assert property (@(posedge clk) disable iff (rst)
    (state_q == S_SCAN && pend_q) |-> ({1'b0, zc_q} <= 8'(chk_q)))
    else $error("zombie count ahead of scan");

endmodule

// ===== hdl/gpst_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpst_slot_ram: slot record memory with per-entry valid bits
// One write and one registered read per cycle; an entry never written since
// reset reads as all zeros.
// ----------------------------------------------------------------------------
module gpst_slot_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 122
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [W-1:0] rd_q;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  // Unwritten entries read as zero through their cleared valid bits
  assign rd_data = rd_vld ? rd_q : '0;

endmodule
